@@ rtl/dda_line_rasterizer_assert.svh @@
// assertion macros used by the top-level rasterizer file
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dda line rasterizer: same-cycle check failed");

// next-cycle implication, disabled during reset
`define DDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dda line rasterizer: next-cycle check failed");

`endif

@@ rtl/dda_pkg.sv @@
package dda_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int STEP_W     = FRAC_BITS + 2;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int LEN_W      = COORD_BITS;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int CNT_W      = $clog2(FRAC_BITS + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [STEP_W-1:0]     step_t;
  typedef logic [LEN_W-1:0]             len_t;

  typedef struct packed {
    logic   operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
    logic   idle_advance;
  } out_item_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_ADVANCE
  } cmd_kind_t;

  // classified command as it sits in the queue
  typedef struct packed {
    cmd_kind_t kind;
    coord_t    x_start;
    coord_t    y_start;
    len_t      x_mag;
    len_t      y_mag;
    logic      x_neg;
    logic      y_neg;
    len_t      len;
    logic      zero_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic pop;
    logic busy;
    logic line_active;
  } back_status_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_DIVIDE
  } back_state_t;

  // fixed point to pixel, truncating toward zero
  function automatic coord_t to_pixel(acc_t acc);
    coord_t whole;
    logic   bump;
    whole = acc[ACC_W-1:FRAC_BITS];
    bump  = acc[ACC_W-1] & (|acc[FRAC_BITS-1:0]);
    return coord_t'(whole + {{(COORD_BITS-1){1'b0}}, bump});
  endfunction

endpackage

@@ rtl/dda_front.sv @@
module dda_front
  import dda_pkg::*;
(
  input  logic         item_valid,
  input  in_item_t     item,
  input  fifo_status_t fifo_status,
  output logic         item_stall,
  output logic         push,
  output cmd_t         cmd
);

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dx_abs;
  logic signed [DIFF_W-1:0] dy_abs;
  len_t                     x_mag;
  len_t                     y_mag;

  // accept whenever the queue has room
  assign item_stall = fifo_status.full;
  assign push       = item_valid & ~fifo_status.full;

  // endpoint differences and their magnitudes
  always_comb begin
    dx     = DIFF_W'(item.x_end) - DIFF_W'(item.x_start);
    dy     = DIFF_W'(item.y_end) - DIFF_W'(item.y_start);
    dx_abs = dx[DIFF_W-1] ? -dx : dx;
    dy_abs = dy[DIFF_W-1] ? -dy : dy;
    x_mag  = dx_abs[LEN_W-1:0];
    y_mag  = dy_abs[LEN_W-1:0];
  end

  // classify into a queue command
  always_comb begin
    cmd.kind     = (item.operation == OP_ADVANCE) ? CMD_ADVANCE : CMD_LOAD;
    cmd.x_start  = item.x_start;
    cmd.y_start  = item.y_start;
    cmd.x_mag    = x_mag;
    cmd.y_mag    = y_mag;
    cmd.x_neg    = dx[DIFF_W-1];
    cmd.y_neg    = dy[DIFF_W-1];
    cmd.len      = (x_mag > y_mag) ? x_mag : y_mag;
    cmd.zero_len = (x_mag == '0) && (y_mag == '0);
  end

endmodule

@@ rtl/dda_fifo.sv @@
module dda_fifo
  import dda_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head_cmd,
  output fifo_status_t status
);

  cmd_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] count;

  assign head_cmd     = entries[rd_ptr];
  assign status.full  = (count == FCNT_W'(FIFO_DEPTH));
  assign status.empty = (count == '0);

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + FCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - FCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/dda_back.sv @@
module dda_back
  import dda_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  input  fifo_status_t fifo_status,
  input  logic         result_stall,
  output logic         result_valid,
  output out_item_t    result,
  output back_status_t status
);

  back_state_t       state;
  back_state_t       state_next;
  logic              pop;

  acc_t              x_acc;
  acc_t              y_acc;
  step_t             x_step;
  step_t             y_step;
  len_t              steps_left;
  logic              line_active;

  len_t              div_len;
  len_t              x_rem;
  len_t              y_rem;
  logic [QUO_W-1:0]  x_quo;
  logic [QUO_W-1:0]  y_quo;
  logic              x_neg;
  logic              y_neg;
  logic [CNT_W-1:0]  div_count;

  acc_t              x_acc_sum;
  acc_t              y_acc_sum;
  logic [LEN_W:0]    x_shift;
  logic [LEN_W:0]    y_shift;
  logic              x_bit;
  logic              y_bit;
  logic              x_first;
  logic              y_first;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BACK_IDLE: begin
        if (pop && cmd.kind == CMD_LOAD && !cmd.zero_len) begin
          state_next = BACK_DIVIDE;
        end
      end
      BACK_DIVIDE: begin
        if (div_count == '0) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  // take a command when idle and the result slot frees up
  always_comb begin
    pop = 1'b0;
    unique case (state)
      BACK_IDLE:   pop = !fifo_status.empty && (!result_valid || !result_stall);
      BACK_DIVIDE: pop = 1'b0;
      default:     pop = 1'b0;
    endcase
  end

  assign status.pop         = pop;
  assign status.busy        = (state == BACK_DIVIDE);
  assign status.line_active = line_active;

  // stepping adders
  always_comb begin
    x_acc_sum = x_acc + {{(ACC_W-STEP_W){x_step[STEP_W-1]}}, x_step};
    y_acc_sum = y_acc + {{(ACC_W-STEP_W){y_step[STEP_W-1]}}, y_step};
  end

  // one restoring division step per lane
  always_comb begin
    x_shift = {x_rem, 1'b0};
    y_shift = {y_rem, 1'b0};
    x_bit   = (x_shift >= {1'b0, div_len});
    y_bit   = (y_shift >= {1'b0, div_len});
    x_first = (cmd.x_mag >= cmd.len);
    y_first = (cmd.y_mag >= cmd.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // line state, divider and result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc       <= '0;
      y_acc       <= '0;
      x_step      <= '0;
      y_step      <= '0;
      steps_left  <= '0;
      line_active <= 1'b0;
      div_count   <= '0;
    end else if (state == BACK_DIVIDE) begin
      if (div_count == '0) begin
        // apply signs and arm the line
        x_step      <= x_neg ? -step_t'({1'b0, x_quo}) : step_t'({1'b0, x_quo});
        y_step      <= y_neg ? -step_t'({1'b0, y_quo}) : step_t'({1'b0, y_quo});
        line_active <= 1'b1;
      end else begin
        x_rem     <= x_bit ? LEN_W'(x_shift - {1'b0, div_len}) : x_shift[LEN_W-1:0];
        y_rem     <= y_bit ? LEN_W'(y_shift - {1'b0, div_len}) : y_shift[LEN_W-1:0];
        x_quo     <= {x_quo[QUO_W-2:0], x_bit};
        y_quo     <= {y_quo[QUO_W-2:0], y_bit};
        div_count <= div_count - CNT_W'(1);
      end
    end else if (pop) begin
      unique case (cmd.kind)
        CMD_LOAD: begin
          x_acc          <= {cmd.x_start, {FRAC_BITS{1'b0}}};
          y_acc          <= {cmd.y_start, {FRAC_BITS{1'b0}}};
          result.pixel_x      <= cmd.x_start;
          result.pixel_y      <= cmd.y_start;
          result.last_pixel   <= cmd.zero_len;
          result.idle_advance <= 1'b0;
          x_step         <= '0;
          y_step         <= '0;
          steps_left     <= cmd.len;
          line_active    <= 1'b0;
          // integer quotient bit first, then the fraction bits
          div_len        <= cmd.len;
          x_neg          <= cmd.x_neg;
          y_neg          <= cmd.y_neg;
          x_rem          <= x_first ? cmd.x_mag - cmd.len : cmd.x_mag;
          y_rem          <= y_first ? cmd.y_mag - cmd.len : cmd.y_mag;
          x_quo          <= {{(QUO_W-1){1'b0}}, x_first};
          y_quo          <= {{(QUO_W-1){1'b0}}, y_first};
          div_count      <= CNT_W'(FRAC_BITS);
        end
        CMD_ADVANCE: begin
          if (line_active) begin
            x_acc               <= x_acc_sum;
            y_acc               <= y_acc_sum;
            steps_left          <= steps_left - LEN_W'(1);
            result.pixel_x      <= to_pixel(x_acc_sum);
            result.pixel_y      <= to_pixel(y_acc_sum);
            result.last_pixel   <= (steps_left == LEN_W'(1));
            result.idle_advance <= 1'b0;
            if (steps_left == LEN_W'(1)) begin
              line_active <= 1'b0;
            end
          end else begin
            result.pixel_x      <= '0;
            result.pixel_y      <= '0;
            result.last_pixel   <= 1'b0;
            result.idle_advance <= 1'b1;
          end
        end
        default: begin
          line_active <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// Input channel item_valid / item_stall / item: operation 0 loads a line from
// (x_start, y_start) to (x_end, y_end), operation 1 advances one pixel.
// Output channel result_valid / result_stall / result: one result per item,
// with the pixel, a last_pixel flag and an idle_advance flag for an advance
// with no line in progress.
// Items enter a four-entry command queue; with the queue empty and the
// output free, an item goes through the queue, then the result register.
// Advances complete at one per cycle while the result is not stalled. A load
// holds the back end while it emits the start pixel, runs the restoring
// divider (an x lane and a y lane, one bit per cycle) that forms the x and y
// increments, then applies signs. Zero-length loads skip the divider.
// item_stall rises when the queue is full. A stall on the result holds the
// output register; the queue keeps taking items until it fills.
// Synchronous reset empties the queue, drops any line and clears result_valid.
module dda_line_rasterizer
  import dda_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

`include "dda_line_rasterizer_assert.svh"

  logic         push;
  cmd_t         push_cmd;
  cmd_t         head_cmd;
  fifo_status_t fifo_status;
  back_status_t back_status;

  // classify incoming items
  dda_front u_front (
    .item_valid  (item_valid),
    .item        (item),
    .fifo_status (fifo_status),
    .item_stall  (item_stall),
    .push        (push),
    .cmd         (push_cmd)
  );

  // command queue
  dda_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (back_status.pop),
    .head_cmd (head_cmd),
    .status   (fifo_status)
  );

  // divider, stepping and result register
  dda_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (head_cmd),
    .fifo_status  (fifo_status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .status       (back_status)
  );

  // checks
  `DDA_ASSERT_NOW(a_pop_not_empty, back_status.pop, !fifo_status.empty)
  `DDA_ASSERT_NOW(a_no_pop_while_dividing, back_status.busy, !back_status.pop)
  `DDA_ASSERT_NOW(a_divide_ends_active, $fell(back_status.busy), back_status.line_active)
  `DDA_ASSERT_NEXT(a_pop_gives_result, back_status.pop, result_valid)

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import dda_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  localparam int TAIL_ITEMS    = 150;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int SETTLE_CYCLES = 32;
  localparam longint FIX_ONE   = longint'(1) << FRAC_BITS;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  dda_line_rasterizer dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #2 clk = ~clk;

  // line state mirrored by the pixel predictor
  acc_t                pos_x, pos_y;
  step_t               inc_x, inc_y;
  logic [DIFF_W-1:0]   steps_to_go;
  logic                drawing;

  out_item_t pending_pixels[$];
  int        fail_count = 0;
  int        sent = 0;
  bit        tail_phase = 1'b0;
  bit        sender_gappy = 1'b1;
  bit        stall_gappy = 1'b1;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // accumulator to pixel, truncated toward zero
  function automatic coord_t whole_pixel(acc_t a);
    longint v;
    v = a;
    return coord_t'(v / FIX_ONE);
  endfunction

  // predict the pixel for one transfer and update the line state
  function automatic out_item_t raster_pixel(in_item_t it);
    out_item_t r;
    longint    dx, dy, span;
    r = '0;
    if (it.operation == OP_LOAD) begin
      dx = longint'($signed(it.x_end)) - longint'($signed(it.x_start));
      dy = longint'($signed(it.y_end)) - longint'($signed(it.y_start));
      span = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                       : (dy < 0 ? -dy : dy);
      pos_x = acc_t'(longint'($signed(it.x_start)) * FIX_ONE);
      pos_y = acc_t'(longint'($signed(it.y_start)) * FIX_ONE);
      r.pixel_x = whole_pixel(pos_x);
      r.pixel_y = whole_pixel(pos_y);
      if (span == 0) begin
        inc_x       = '0;
        inc_y       = '0;
        steps_to_go = '0;
        drawing     = 1'b0;
        r.last_pixel = 1'b1;
      end else begin
        inc_x       = step_t'((dx * FIX_ONE) / span);
        inc_y       = step_t'((dy * FIX_ONE) / span);
        steps_to_go = span[DIFF_W-1:0];
        drawing     = 1'b1;
      end
    end else if (!drawing) begin
      r.idle_advance = 1'b1;
    end else begin
      pos_x = pos_x + inc_x;
      pos_y = pos_y + inc_y;
      if (steps_to_go > 0) steps_to_go = steps_to_go - 1'b1;
      r.pixel_x = whole_pixel(pos_x);
      r.pixel_y = whole_pixel(pos_y);
      if (steps_to_go == 0) begin
        r.last_pixel = 1'b1;
        drawing      = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic in_item_t mk_item(logic op, int xs, int ys, int xe, int ye);
    in_item_t it;
    it.operation = op;
    it.x_start   = coord_t'(xs);
    it.y_start   = coord_t'(ys);
    it.x_end     = coord_t'(xe);
    it.y_end     = coord_t'(ye);
    return it;
  endfunction

  function automatic out_item_t mk_pixel(int px, int py, logic last, logic idle);
    out_item_t r;
    r.pixel_x      = coord_t'(px);
    r.pixel_y      = coord_t'(py);
    r.last_pixel   = last;
    r.idle_advance = idle;
    return r;
  endfunction

  function automatic void add_row(in_item_t stim, bit fixed, out_item_t want);
    directed_row_t row;
    row.stim  = stim;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic int rand_coord();
    coord_t c;
    c = coord_t'($urandom);
    return int'(c);
  endfunction

  function automatic int clip_coord(int v);
    if (v < -(1 << (COORD_BITS - 1))) return -(1 << (COORD_BITS - 1));
    if (v > (1 << (COORD_BITS - 1)) - 1) return (1 << (COORD_BITS - 1)) - 1;
    return v;
  endfunction

  function automatic in_item_t rand_item(logic op);
    in_item_t    it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  // report one failure, details only for the first few
  function automatic void note_failure(string what, out_item_t want, out_item_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected x=%0d y=%0d last=%0b idle=%0b, got x=%0d y=%0d last=%0b idle=%0b",
               what, $signed(want.pixel_x), $signed(want.pixel_y), want.last_pixel,
               want.idle_advance, $signed(got.pixel_x), $signed(got.pixel_y),
               got.last_pixel, got.idle_advance);
  endfunction

  // drive one input transfer, optionally after an idle burst
  task automatic send_item(in_item_t it, bit fixed = 1'b0, out_item_t want = '0);
    int        gap;
    out_item_t predicted;
    gap = 0;
    if (!tail_phase && sender_gappy && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = raster_pixel(it);
    pending_pixels.insert(pending_pixels.size(), fixed ? want : predicted);
    sent++;
    if ($urandom_range(0, 63) == 0) sender_gappy = !sender_gappy;
    if (sent >= ITEM_TARGET - TAIL_ITEMS) tail_phase = 1'b1;
  endtask

  // hold off the sender until every pixel has come back
  task automatic drain_pixels();
    item_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // one load followed by a run of advances, or a burst of noise
  task automatic random_line();
    int xs, ys, xe, ye, n, adv, kind;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 4)) send_item(rand_item(1'($urandom_range(0, 1))));
      return;
    end
    xs = rand_coord();
    ys = rand_coord();
    if (kind <= 6) begin
      xe = clip_coord(xs + $urandom_range(0, 48) - 24);
      ye = clip_coord(ys + $urandom_range(0, 48) - 24);
    end else if (kind == 7) begin
      xe = rand_coord();
      ye = rand_coord();
    end else begin
      xe = xs;
      ye = ys;
    end
    n = (xe > xs ? xe - xs : xs - xe);
    if ((ye > ys ? ye - ys : ys - ye) > n) n = (ye > ys ? ye - ys : ys - ye);
    if (kind <= 6)
      adv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
    else if (kind == 7)
      adv = (n <= 400 && $urandom_range(0, 3) == 0) ? n : $urandom_range(0, 40);
    else
      adv = $urandom_range(0, 1);
    send_item(mk_item(OP_LOAD, xs, ys, xe, ye));
    repeat (adv) send_item(rand_item(OP_ADVANCE));
  endtask

  // result side idle bursts
  always @(posedge clk) begin
    if (rst || tail_phase) begin
      result_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_gappy = !stall_gappy;
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (stall_gappy && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // check each result transfer against the oldest predicted pixel
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_pixels.size() == 0) begin
        note_failure("unexpected pixel", '0, result);
      end else begin
        want = pending_pixels.pop_front();
        if (result.pixel_x !== want.pixel_x || result.pixel_y !== want.pixel_y ||
            result.last_pixel !== want.last_pixel ||
            result.idle_advance !== want.idle_advance)
          note_failure("pixel mismatch", want, result);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    inc_x       = '0;
    inc_y       = '0;
    steps_to_go = '0;
    drawing     = 1'b0;

    // directed rows: reset, zero-length, extremes, reload mid-line, signs
    add_row(mk_item(OP_ADVANCE, 0, 0, 0, 0), 1, mk_pixel(0, 0, 0, 1));
    add_row(mk_item(OP_LOAD, -2048, 2047, -2048, 2047), 1, mk_pixel(-2048, 2047, 1, 0));
    add_row(mk_item(OP_ADVANCE, 2047, -2048, 2047, -2048), 1, mk_pixel(0, 0, 0, 1));
    add_row(mk_item(OP_LOAD, 0, 0, 3, 1), 1, mk_pixel(0, 0, 0, 0));
    repeat (3) add_row(mk_item(OP_ADVANCE, -1, -1, -1, -1), 0, '0);
    add_row(mk_item(OP_ADVANCE, 0, 0, 0, 0), 1, mk_pixel(0, 0, 0, 1));
    add_row(mk_item(OP_LOAD, -2048, -2048, 2047, 2047), 1, mk_pixel(-2048, -2048, 0, 0));
    repeat (2) add_row(mk_item(OP_ADVANCE, 0, 0, 0, 0), 0, '0);
    // load while a line is still in progress
    add_row(mk_item(OP_LOAD, 2047, -2048, -2048, 2047), 1, mk_pixel(2047, -2048, 0, 0));
    repeat (2) add_row(mk_item(OP_ADVANCE, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(OP_LOAD, 0, 0, -5, 3), 1, mk_pixel(0, 0, 0, 0));
    repeat (5) add_row(mk_item(OP_ADVANCE, 0, 0, 0, 0), 0, '0);
    add_row(mk_item(OP_LOAD, 1, 1, 2, -7), 1, mk_pixel(1, 1, 0, 0));
    repeat (2) add_row(mk_item(OP_ADVANCE, 0, 0, 0, 0), 0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
    drain_pixels();

    while (sent < ITEM_TARGET) begin
      if (!drained_mid && sent >= ITEM_TARGET / 2) begin
        drain_pixels();
        drained_mid = 1'b1;
      end
      random_line();
    end
    item_valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
